/* src/hcbd_pkg.sv */
`default_nettype none
package hcbd_pkg;

  // Widths fixed by the item and register layout
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 32;
  localparam int unsigned LimitW     = 8;
  localparam int unsigned SizeBitsDef = 32;

  // Register map
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic [ApbAddrW-1:0] RegLineLimit = 3'd0;
  localparam logic [LimitW-1:0]   LineLimitRst = 8'd95;

  // Character codes
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;

  // Payload layout of the stream channels
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  typedef struct packed {
    logic             ok;
    logic [3:0]       val;
  } hex_t;

  // One result beat
  typedef struct packed {
    logic [CountW-1:0] bytes_so_far;
    logic              failed;
    logic              finished;
    logic              byte_valid;
    logic [ByteW-1:0]  out_byte;
  } res_t;

  // Decode one ASCII hex digit
  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

/* src/http_chunked_body_decoder_top.sv */
`default_nettype none
// HTTP/1.1 chunked body decoder.
// Slave stream: one body byte per beat, tdata = in_byte, tuser = closed (end of
// connection; the byte is then ignored). Master stream: one result per input beat,
// tdata = out_byte, finished, failed, bytes_so_far; tuser = byte_valid, set when
// out_byte is chunk payload. Results leave in input order.
// An accepted byte passes the input slice, the decode logic and the output slice before it
// appears on the master side. Throughput is one byte per cycle while the receiver does not
// stall, set by the single decode step between the two register slices.
// When the receiver stalls, the output slice holds its beat, the input slice fills,
// and s_axis_tready drops; no beat is lost or repeated.
// Reset clears both slices, returns the parser to the start of a size line with a
// zero byte count, and sets line_limit to 95. line_limit (address 0) may be
// written over the APB port only while the stream is idle; pready is always high.
module http_chunked_body_decoder_top #(
  parameter int unsigned SizeBits = hcbd_pkg::SizeBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // [7:0] in_byte
  input  wire logic [hcbd_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] closed
  input  wire logic [0:0]                        s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] out_byte, [8] finished, [9] failed, [41:10] bytes_so_far, [47:42] zero
  output logic [hcbd_pkg::OutDataW-1:0]          m_axis_tdata,
  // [0] byte_valid
  output logic [0:0]                             m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hcbd_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [hcbd_pkg::ApbDataW-1:0]     pwdata,
  output logic [hcbd_pkg::ApbDataW-1:0]          prdata,
  output logic                                   pready
);

  localparam int unsigned InW = hcbd_pkg::InDataW + 1;
  localparam int unsigned ResW = $bits(hcbd_pkg::res_t);

  logic [hcbd_pkg::LimitW-1:0] limit_q;
  logic                        in_valid;
  logic [InW-1:0]              in_data;
  logic                        res_ready;
  logic                        step;
  hcbd_pkg::res_t              res;
  logic [ResW-1:0]             res_out;
  hcbd_pkg::res_t              res_beat;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == hcbd_pkg::RegLineLimit) ?
                  hcbd_pkg::ApbDataW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hcbd_pkg::LineLimitRst;
    end else if (psel && penable && pwrite && pready &&
                 paddr == hcbd_pkg::RegLineLimit) begin
      limit_q <= pwdata[hcbd_pkg::LimitW-1:0];
    end
  end

  // Input slice
  hcbd_stage #(.Width(InW)) u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   ({s_axis_tuser, s_axis_tdata}),
    .out_valid_o (in_valid),
    .out_ready_i (res_ready),
    .out_data_o  (in_data)
  );

  assign step = in_valid && res_ready;

  hcbd_core #(.SizeBits(SizeBits)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_data[hcbd_pkg::ByteW-1:0]),
    .closed_i     (in_data[InW-1]),
    .line_limit_i (limit_q),
    .res_o        (res)
  );

  // Output slice
  hcbd_stage #(.Width(ResW)) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  assign res_beat = res_out;

  // Pack result beat
  assign m_axis_tdata = {6'd0, res_beat.bytes_so_far, res_beat.failed, res_beat.finished,
                         res_beat.out_byte};
  assign m_axis_tuser = res_beat.byte_valid;

endmodule
`default_nettype wire

/* src/hcbd_stage.sv */
`default_nettype none
// Single register slice with valid/ready; full rate, ready looks one stage ahead
module hcbd_stage #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Width-1:0]      out_data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // Take a new beat when empty or when the held beat leaves this cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

/* src/hcbd_core.sv */
`default_nettype none
// Decoder state and its one-byte update
module hcbd_core #(
  parameter int unsigned SizeBits = hcbd_pkg::SizeBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [hcbd_pkg::ByteW-1:0]   byte_i,
  input  wire logic                         closed_i,
  input  wire logic [hcbd_pkg::LimitW-1:0]  line_limit_i,
  output hcbd_pkg::res_t                    res_o
);

  localparam logic [2:0] PhSize    = 3'd0;
  localparam logic [2:0] PhData    = 3'd1;
  localparam logic [2:0] PhPost    = 3'd2;
  localparam logic [2:0] PhTrailer = 3'd3;
  localparam logic [2:0] PhDone    = 3'd4;
  localparam logic [2:0] PhFail    = 3'd5;

  localparam logic [1:0] HxSkip    = 2'd0;
  localparam logic [1:0] HxDigits  = 2'd1;
  localparam logic [1:0] HxStop    = 2'd2;

  logic [2:0]                        phase_q, phase_d;
  logic [SizeBits-1:0]               remaining_q, remaining_d;
  logic [hcbd_pkg::LimitW-1:0]       chars_q, chars_d;
  logic                              cr_q, cr_d;
  logic [1:0]                        hex_q, hex_d;
  logic [hcbd_pkg::CountW-1:0]       total_q, total_d;

  // Line tracking shared by size, post-data and trailer lines
  logic                              line_done;
  logic                              line_long;
  logic [hcbd_pkg::LimitW-1:0]       chars_inc;
  hcbd_pkg::hex_t                    hx;
  logic                              is_ws;
  logic [SizeBits-1:0]               size_acc;
  logic                              valid;

  assign line_done = cr_q && (byte_i == hcbd_pkg::ChLf);
  assign chars_inc = (chars_q == '1) ? chars_q : chars_q + 1'b1;
  assign line_long = chars_inc >= line_limit_i;
  assign hx        = hcbd_pkg::hex_decode(byte_i);
  assign is_ws     = (byte_i == hcbd_pkg::ChSpace) || (byte_i == hcbd_pkg::ChTab);

  // Shifting in a digit overflows exactly when the top nibble is set
  assign size_acc = (remaining_q[SizeBits-1 -: 4] != 4'd0) ? '1 :
                    {remaining_q[SizeBits-5:0], hx.val};

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    chars_d     = chars_q;
    cr_d        = cr_q;
    hex_d       = hex_q;
    total_d     = total_q;
    valid       = 1'b0;
    if (closed_i) begin
      if (phase_q != PhDone) begin
        phase_d = PhFail;
      end
    end else begin
      case (phase_q)
        PhSize: begin
          // Accumulate the hex size, skip leading blanks, stop at first other char
          if (hex_q != HxStop && !(hex_q == HxSkip && is_ws)) begin
            if (hx.ok) begin
              hex_d       = HxDigits;
              remaining_d = size_acc;
            end else begin
              hex_d = HxStop;
            end
          end
          chars_d = chars_inc;
          cr_d    = (byte_i == hcbd_pkg::ChCr);
          if (line_done) begin
            phase_d = (remaining_d == '0) ? PhTrailer : PhData;
            chars_d = '0;
            cr_d    = 1'b0;
            hex_d   = HxSkip;
          end else if (line_long) begin
            phase_d = PhFail;
          end
        end
        PhData: begin
          valid       = 1'b1;
          total_d     = (total_q == '1) ? total_q : total_q + 1'b1;
          remaining_d = remaining_q - 1'b1;
          if (remaining_d == '0) begin
            phase_d = PhPost;
            chars_d = '0;
            cr_d    = 1'b0;
            hex_d   = HxSkip;
          end
        end
        PhPost, PhTrailer: begin
          chars_d = chars_inc;
          cr_d    = (byte_i == hcbd_pkg::ChCr);
          if (line_done) begin
            phase_d     = (phase_q == PhPost) ? PhSize : PhDone;
            remaining_d = '0;
            chars_d     = '0;
            cr_d        = 1'b0;
            hex_d       = HxSkip;
          end else if (line_long) begin
            phase_d = PhFail;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Result of the current byte, registered by the output stage
  always_comb begin
    res_o.out_byte     = valid ? byte_i : '0;
    res_o.byte_valid   = valid;
    res_o.finished     = (phase_d == PhDone);
    res_o.failed       = (phase_d == PhFail);
    res_o.bytes_so_far = total_d;
  end

  // Advance state only on a byte that moves into the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSize;
      remaining_q <= '0;
      chars_q     <= '0;
      cr_q        <= 1'b0;
      hex_q       <= HxSkip;
      total_q     <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      chars_q     <= chars_d;
      cr_q        <= cr_d;
      hex_q       <= hex_d;
      total_q     <= total_d;
    end
  end

endmodule
`default_nettype wire

/* test/tb_http_chunked_body_decoder_top.sv */
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_top;

  localparam int unsigned SizeBits   = hcbd_pkg::SizeBitsDef;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam logic [63:0] SizeMax    = 64'({SizeBits{1'b1}});
  localparam logic [7:0]  ChVtab     = 8'h0b;

  typedef enum logic [2:0] {
    PhSizeLine, PhPayload, PhAfterData, PhTrailer, PhDone, PhFailed
  } phase_e;
  typedef enum logic [1:0] {HexSkip, HexDigits, HexStopped} hex_e;
  typedef enum logic [1:0] {LineMore, LineDone, LineTooLong} line_e;
  typedef enum logic [1:0] {EndZeroChunk, EndNoDigits, EndOverlong, EndSaturated} ending_e;

  // One decoded result beat
  typedef struct packed {
    logic [31:0] count;
    logic        fail;
    logic        fin;
    logic        vld;
    logic [7:0]  data;
  } decoded_t;

  logic                                clk_i;
  logic                                rst_ni        = 1'b0;
  logic [hcbd_pkg::InDataW-1:0]        s_axis_tdata  = '0;
  logic [0:0]                          s_axis_tuser  = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [hcbd_pkg::OutDataW-1:0]       m_axis_tdata;
  logic [0:0]                          m_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic                                psel          = 1'b0;
  logic                                penable       = 1'b0;
  logic                                pwrite        = 1'b0;
  logic [hcbd_pkg::ApbAddrW-1:0]       paddr         = '0;
  logic [hcbd_pkg::ApbDataW-1:0]       pwdata        = '0;
  logic [hcbd_pkg::ApbDataW-1:0]       prdata;
  logic                                pready;

  // Decoder state as predicted from the accepted beats
  phase_e      dec_phase      = PhSizeLine;
  logic [63:0] dec_remaining  = '0;
  logic [7:0]  dec_line_chars = '0;
  logic        dec_prev_cr    = 1'b0;
  hex_e        dec_hex        = HexSkip;
  logic [31:0] dec_total      = '0;
  logic [7:0]  dec_limit      = hcbd_pkg::LineLimitRst;

  decoded_t    decoded_beats[$];
  decoded_t    want_beat;
  int unsigned mismatches      = 0;
  int unsigned body_bytes_sent = 0;
  int unsigned cycle_count     = 0;
  int unsigned rx_hold         = 0;
  logic        tx_gaps_on      = 1'b1;
  logic        rx_stalls_on    = 1'b1;

  http_chunked_body_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte that cannot close a line
  function automatic logic [7:0] junk_char();
    logic [7:0] b;
    do b = 8'($urandom); while (b == hcbd_pkg::ChLf);
    return b;
  endfunction

  function automatic void open_line();
    dec_line_chars = '0;
    dec_prev_cr    = 1'b0;
    dec_hex        = HexSkip;
  endfunction

  // Count one line character and tell whether the line closed or ran too long
  function automatic line_e take_line_char(input logic [7:0] c);
    logic ends;
    ends = dec_prev_cr && (c == hcbd_pkg::ChLf);
    if (dec_line_chars != 8'hff) dec_line_chars++;
    dec_prev_cr = (c == hcbd_pkg::ChCr);
    if (ends) return LineDone;
    if (dec_line_chars >= dec_limit) return LineTooLong;
    return LineMore;
  endfunction

  // Advance the predicted decoder by one body byte
  function automatic decoded_t decode_byte(input logic [7:0] c, input logic closed);
    decoded_t r;
    line_e    ln;
    logic [3:0] digit;
    logic     digit_ok;
    r = '0;
    if (closed) begin
      if (dec_phase != PhDone) dec_phase = PhFailed;
    end else begin
      case (dec_phase)
        PhSizeLine: begin
          if (dec_hex != HexStopped &&
              !(dec_hex == HexSkip &&
                (c == hcbd_pkg::ChSpace || c == hcbd_pkg::ChTab))) begin
            digit_ok = 1'b1;
            digit    = '0;
            if (c >= "0" && c <= "9") digit = 4'(c - "0");
            else if (c >= "a" && c <= "f") digit = 4'(c - "a" + 10);
            else if (c >= "A" && c <= "F") digit = 4'(c - "A" + 10);
            else digit_ok = 1'b0;
            if (!digit_ok) begin
              dec_hex = HexStopped;
            end else begin
              dec_hex = HexDigits;
              // saturate instead of wrapping
              if (dec_remaining > (SizeMax - 64'(digit)) / 16) dec_remaining = SizeMax;
              else dec_remaining = dec_remaining * 16 + 64'(digit);
            end
          end
          ln = take_line_char(c);
          if (ln == LineTooLong) begin
            dec_phase = PhFailed;
          end else if (ln == LineDone) begin
            dec_phase = (dec_remaining == 0) ? PhTrailer : PhPayload;
            open_line();
          end
        end
        PhPayload: begin
          r.vld  = 1'b1;
          r.data = c;
          if (dec_total != '1) dec_total++;
          dec_remaining = (dec_remaining - 1) & SizeMax;
          if (dec_remaining == 0) begin
            dec_phase = PhAfterData;
            open_line();
          end
        end
        PhAfterData, PhTrailer: begin
          ln = take_line_char(c);
          if (ln == LineTooLong) begin
            dec_phase = PhFailed;
          end else if (ln == LineDone) begin
            dec_phase     = (dec_phase == PhAfterData) ? PhSizeLine : PhDone;
            dec_remaining = '0;
            open_line();
          end
        end
        default: ;
      endcase
    end
    r.fin   = (dec_phase == PhDone);
    r.fail  = (dec_phase == PhFailed);
    r.count = dec_total;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Check each result beat against the oldest prediction, then predict new input beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, actual %h/%h",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want_beat = decoded_beats.pop_front();
          compare_field("out_byte", 32'(want_beat.data), 32'(m_axis_tdata[7:0]));
          compare_field("byte_valid", 32'(want_beat.vld), 32'(m_axis_tuser[0]));
          compare_field("finished", 32'(want_beat.fin), 32'(m_axis_tdata[8]));
          compare_field("failed", 32'(want_beat.fail), 32'(m_axis_tdata[9]));
          compare_field("bytes_so_far", want_beat.count, m_axis_tdata[41:10]);
          compare_field("tdata pad", '0, 32'(m_axis_tdata[47:42]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        decoded_beats.push_back(decode_byte(s_axis_tdata, s_axis_tuser[0]));
    end
  end

  // Receiver: stall at random, or not at all while stalls are off
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
      rx_hold       <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** http_chunked_body_decoder_top: FAILED **");
      $finish;
    end
  end

  // Offer one beat and hold it until it is taken
  task automatic send_byte(input logic [7:0] b, input logic closed);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= closed;
    do @(posedge clk_i); while (!s_axis_tready);
    body_bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_crlf();
    send_byte(hcbd_pkg::ChCr, 1'b0);
    send_byte(hcbd_pkg::ChLf, 1'b0);
  endtask

  // Junk line closed by CRLF, sometimes filling the line limit exactly
  task automatic send_junk_line();
    int unsigned n;
    int unsigned room;
    room = dec_limit - 2;
    n = ($urandom_range(0, 3) == 0) ? room : $urandom_range(1, (room < 12) ? room : 12);
    repeat (n) send_byte(junk_char(), 1'b0);
    send_crlf();
  endtask

  // Size line with optional blanks, leading zeros, mixed case and an extension
  task automatic send_size_line(input logic [31:0] want, output logic [31:0] size);
    int unsigned budget, ndig, n_ws, n_zero, n_ext;
    logic [3:0]  nib;
    size   = want;
    budget = dec_limit - 2;
    ndig   = 1;
    while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
    if (ndig > budget) begin
      size = $urandom_range(1, 15);
      ndig = 1;
    end
    budget -= ndig;
    n_ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (n_ws > budget) n_ws = budget;
    budget -= n_ws;
    n_zero = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    if (n_zero > budget) n_zero = budget;
    budget -= n_zero;
    n_ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    if (n_ext > budget) n_ext = budget;
    repeat (n_ws) send_byte($urandom_range(0, 1) ? hcbd_pkg::ChSpace : hcbd_pkg::ChTab,
                            1'b0);
    repeat (n_zero) send_byte("0", 1'b0);
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = size[4 * i +: 4];
      if (nib < 10) send_byte(8'("0" + nib), 1'b0);
      else send_byte(8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10), 1'b0);
    end
    if (n_ext != 0) begin
      send_byte(";", 1'b0);
      repeat (n_ext - 1) send_byte(junk_char(), 1'b0);
    end
    send_crlf();
  endtask

  task automatic send_chunk(input logic [31:0] want);
    logic [31:0] size;
    send_size_line(want, size);
    repeat (size) send_byte(8'($urandom), 1'b0);
    if ($urandom_range(0, 6) == 0) send_junk_line();
    else send_crlf();
  endtask

  // Stop sending and let every predicted beat come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decoded_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [hcbd_pkg::ApbAddrW-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == hcbd_pkg::RegLineLimit) dec_limit = data[7:0];
  endtask

  task automatic apb_read(input logic [hcbd_pkg::ApbAddrW-1:0] addr,
                          input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    compare_field("prdata", want, prdata);
  endtask

  task automatic test_register_reset();
    apb_read(hcbd_pkg::RegLineLimit, 32'(hcbd_pkg::LineLimitRst));
  endtask

  // Blanks before digits, extension, extreme payload bytes, stray CR in a line,
  // early stop of the number, and lines that fill the tightest limit
  task automatic test_edge_lines();
    send_text("\t 2;q");
    send_crlf();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(hcbd_pkg::ChCr, 1'b0);
    send_crlf();
    send_text("1");
    send_byte(ChVtab, 1'b0);
    send_text("7");
    send_crlf();
    send_byte(hcbd_pkg::ChLf, 1'b0);
    send_crlf();
    wait_drained();
    apb_write(hcbd_pkg::RegLineLimit, 32'd3);
    send_text("1");
    send_crlf();
    send_byte(hcbd_pkg::ChCr, 1'b0);
    send_text("Z");
    send_crlf();
  endtask

  // Well-formed chunks with random content under one line limit
  task automatic test_random_chunks(input logic [7:0] limit, input int unsigned n_items,
                                    input logic idle);
    int unsigned start;
    int unsigned r;
    wait_drained();
    apb_write(hcbd_pkg::RegLineLimit, 32'(limit));
    apb_read(hcbd_pkg::RegLineLimit, 32'(limit));
    tx_gaps_on   = idle;
    rx_stalls_on = idle;
    start = body_bytes_sent;
    while (body_bytes_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_chunk($urandom_range(1, 16));
      else if (r < 92) send_chunk($urandom_range(17, 120));
      else send_chunk($urandom_range(121, 400));
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Close the message one of several ways, then feed bytes that must be ignored
  task automatic test_message_end();
    ending_e     kind;
    logic [31:0] size;
    wait_drained();
    apb_write(hcbd_pkg::RegLineLimit, 32'($urandom_range(16, 255)));
    kind = ending_e'($urandom_range(0, 3));
    case (kind)
      EndZeroChunk: begin
        send_size_line('0, size);
        if ($urandom_range(0, 1)) send_junk_line();
        else send_crlf();
      end
      EndNoDigits: begin
        case ($urandom_range(0, 5))
          0: send_text("+5");
          1: send_text("-3");
          2: send_text("0x1F");
          3: send_text(";x=1");
          4: ;
          default: begin
            send_byte(ChVtab, 1'b0);
            send_text("7");
          end
        endcase
        send_crlf();
        send_junk_line();
      end
      EndOverlong: begin
        // overrun either a size line or a post-data line
        if ($urandom_range(0, 1)) begin
          send_size_line(32'd1, size);
          repeat (size) send_byte(8'($urandom), 1'b0);
        end
        repeat (dec_limit) send_byte(junk_char(), 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1)) send_text("FFFFFFFFF");
        else send_text("1fffffffff0");
        send_crlf();
        repeat (40) send_byte(8'($urandom), 1'b0);
      end
    endcase
    send_byte(8'($urandom), 1'b1);
    repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_reset();
    test_edge_lines();
    test_random_chunks(8'd255, 320, 1'b1);
    test_random_chunks(8'd3, 220, 1'b0);
    test_random_chunks(8'($urandom_range(4, 254)), 360, 1'b1);
    test_random_chunks(hcbd_pkg::LineLimitRst, 320, 1'b1);
    test_message_end();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** http_chunked_body_decoder_top: PASSED **");
    end else begin
      $display("** http_chunked_body_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/hcbd_pkg.sv
src/hcbd_stage.sv
src/hcbd_core.sv
src/http_chunked_body_decoder_top.sv
test/tb_http_chunked_body_decoder_top.sv
